// ===== rtl/core/fdr_pkg.sv =====
// ----------------------------------------------------------------------------
// Fresnel reflectance package
// Shared widths, fixed-point constants and the sideband carried down the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package fdr_pkg;

   localparam int SQRT_BITS  = 15;
   localparam int SNELL_BITS = 14;
   localparam int RATIO_BITS = 16;

   localparam logic [15:0] ONE_Q14 = 16'd16384;
   localparam logic [15:0] ONE_Q15 = 16'd32768;
   localparam logic [28:0] RAD_ONE = 29'h1000_0000;

   typedef struct packed {
      logic [14:0] cu;
      logic [15:0] ni;
      logic [15:0] nt;
      logic        tir;
   } fdr_side_type;

endpackage

`default_nettype wire

// ===== rtl/core/fdr_sqrt.sv =====
// ----------------------------------------------------------------------------
// Fresnel complementary square root
// Pipelined floor(sqrt(1 - x^2)) in Q1.14, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fdr_sqrt (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [14:0]          in_x,
   input  wire fdr_pkg::fdr_side_type in_side,
   output logic                      out_valid,
   output logic [14:0]               out_root,
   output fdr_pkg::fdr_side_type     out_side
);

   logic [fdr_pkg::SQRT_BITS+1:0] vld_ff;
   fdr_pkg::fdr_side_type         side_ff [0:fdr_pkg::SQRT_BITS+1];
   logic [28:0]                   sq_ff;
   logic [28:0]                   rem_ff [0:fdr_pkg::SQRT_BITS];
   logic [14:0]                   res_ff [0:fdr_pkg::SQRT_BITS];
   logic [29:0]                   sq_in;

   assign sq_in = 30'(in_x) * 30'(in_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[fdr_pkg::SQRT_BITS:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int j = 1; j <= fdr_pkg::SQRT_BITS + 1; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
         sq_ff     <= sq_in[28:0];
         rem_ff[0] <= fdr_pkg::RAD_ONE - sq_ff;
         res_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < fdr_pkg::SQRT_BITS; i++) begin : g_step
      localparam int B = fdr_pkg::SQRT_BITS - 1 - i;
      logic [30:0] trial;
      logic        take;
      assign trial = ({16'd0, res_ff[i]} << (B + 1)) + (31'd1 << (2 * B));
      assign take  = {2'b00, rem_ff[i]} >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= take ? (rem_ff[i] - trial[28:0]) : rem_ff[i];
            res_ff[i+1] <= take ? (res_ff[i] | (15'd1 << B)) : res_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[fdr_pkg::SQRT_BITS+1];
   assign out_root  = res_ff[fdr_pkg::SQRT_BITS];
   assign out_side  = side_ff[fdr_pkg::SQRT_BITS+1];

endmodule

`default_nettype wire

// ===== rtl/core/fdr_snell.sv =====
// ----------------------------------------------------------------------------
// Fresnel Snell divider
// Pipelined restoring divide of ni*sin_i by nt, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fdr_snell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [30:0]          in_prod,
   input  wire fdr_pkg::fdr_side_type in_side,
   output logic                      out_valid,
   output logic [13:0]               out_quo,
   output fdr_pkg::fdr_side_type     out_side
);

   logic [fdr_pkg::SNELL_BITS:0] vld_ff;
   fdr_pkg::fdr_side_type        side_ff [0:fdr_pkg::SNELL_BITS];
   logic [15:0]                  r_ff [0:fdr_pkg::SNELL_BITS];
   logic [13:0]                  p_ff [0:fdr_pkg::SNELL_BITS];
   logic [13:0]                  q_ff [0:fdr_pkg::SNELL_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[fdr_pkg::SNELL_BITS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         r_ff[0]    <= in_prod[29:14];
         p_ff[0]    <= in_prod[13:0];
         q_ff[0]    <= '0;
      end
   end

   for (genvar i = 0; i < fdr_pkg::SNELL_BITS; i++) begin : g_step
      localparam int B = fdr_pkg::SNELL_BITS - 1 - i;
      logic [16:0] r2;
      logic [16:0] diff;
      logic        take;
      assign r2   = {r_ff[i], p_ff[i][B]};
      assign diff = r2 - {1'b0, side_ff[i].nt};
      assign take = r2 >= {1'b0, side_ff[i].nt};
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i+1] <= side_ff[i];
            p_ff[i+1]    <= p_ff[i];
            r_ff[i+1]    <= take ? diff[15:0] : r2[15:0];
            q_ff[i+1]    <= take ? (q_ff[i] | (14'd1 << B)) : q_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[fdr_pkg::SNELL_BITS];
   assign out_quo   = q_ff[fdr_pkg::SNELL_BITS];
   assign out_side  = side_ff[fdr_pkg::SNELL_BITS];

endmodule

`default_nettype wire

// ===== rtl/core/fdr_ratio.sv =====
// ----------------------------------------------------------------------------
// Fresnel amplitude ratio divider
// Two-lane pipelined divide num*2^15/den, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fdr_ratio (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [1:0][31:0] in_num,
   input  wire logic [1:0][31:0] in_den,
   input  wire logic             in_tir,
   output logic                  out_valid,
   output logic [1:0][15:0]      out_quo,
   output logic                  out_tir
);

   logic [fdr_pkg::RATIO_BITS:0] vld_ff;
   logic [fdr_pkg::RATIO_BITS:0] tir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[fdr_pkg::RATIO_BITS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tir_ff <= {tir_ff[fdr_pkg::RATIO_BITS-1:0], in_tir};
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [31:0] r_ff   [0:fdr_pkg::RATIO_BITS];
      logic [31:0] den_ff [0:fdr_pkg::RATIO_BITS];
      logic [15:0] q_ff   [0:fdr_pkg::RATIO_BITS];

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[0]   <= in_num[l];
            den_ff[0] <= in_den[l];
            q_ff[0]   <= '0;
         end
      end

      for (genvar i = 0; i < fdr_pkg::RATIO_BITS; i++) begin : g_step
         localparam int B = fdr_pkg::RATIO_BITS - 1 - i;
         logic [32:0] r2;
         logic [32:0] diff;
         logic        take;
         if (i == 0) begin : g_first
            assign r2 = {1'b0, r_ff[i]};
         end else begin : g_next
            assign r2 = {r_ff[i], 1'b0};
         end
         assign diff = r2 - {1'b0, den_ff[i]};
         assign take = r2 >= {1'b0, den_ff[i]};
         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[i+1] <= den_ff[i];
               r_ff[i+1]   <= take ? diff[31:0] : r2[31:0];
               q_ff[i+1]   <= take ? (q_ff[i] | (16'd1 << B)) : q_ff[i];
            end
         end
      end

      assign out_quo[l] = q_ff[fdr_pkg::RATIO_BITS];
   end

   assign out_valid = vld_ff[fdr_pkg::RATIO_BITS];
   assign out_tir   = tir_ff[fdr_pkg::RATIO_BITS];

endmodule

`default_nettype wire

// ===== rtl/core/dielectric_fresnel_reflectance_unit.sv =====
// ----------------------------------------------------------------------------
// Dielectric Fresnel reflectance unit
// Unpolarized Fresnel reflectance of a dielectric boundary, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while req_ready is high and returns one result beat
// per input beat, in order. The pipe is built from the bit-per-stage units: two
// 17-stage square roots, a 15-stage Snell divider and a 17-stage ratio divider.
// All stages advance together; a stalled result holds the whole pipe and
// req_ready drops only while rsp_valid is high and rsp_ready is low.
`default_nettype none

module dielectric_fresnel_reflectance_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_cos_incident,
   input  wire logic [15:0] req_ior_outside,
   input  wire logic [15:0] req_ior_inside,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_reflectance,
   output logic             rsp_total_internal
);

   logic en;

   logic                  in_v_ff;
   fdr_pkg::fdr_side_type in_side_ff;
   fdr_pkg::fdr_side_type in_side_in;
   logic signed [15:0]    cos_s;
   logic signed [15:0]    cos_c;

   logic                  s1_valid;
   logic [14:0]           s1_root;
   fdr_pkg::fdr_side_type s1_side;

   logic                  p_v_ff;
   logic [30:0]           p_ff;
   fdr_pkg::fdr_side_type p_side_ff;

   logic                  t_v_ff;
   logic [30:0]           t_prod_ff;
   fdr_pkg::fdr_side_type t_side_ff;
   fdr_pkg::fdr_side_type t_side_in;

   logic                  sn_valid;
   logic [13:0]           sn_quo;
   fdr_pkg::fdr_side_type sn_side;

   logic                  s2_valid;
   logic [14:0]           s2_root;
   fdr_pkg::fdr_side_type s2_side;

   logic                  m_v_ff;
   logic                  m_tir_ff;
   logic [1:0][30:0]      ma_ff;
   logic [1:0][30:0]      mb_ff;

   logic                  d_v_ff;
   logic                  d_tir_ff;
   logic [1:0][31:0]      num_ff;
   logic [1:0][31:0]      den_ff;

   logic                  r_valid;
   logic [1:0][15:0]      r_quo;
   logic                  r_tir;

   logic                  q_v_ff;
   logic                  q_tir_ff;
   logic [1:0][30:0]      qsq_ff;
   logic [1:0][15:0]      qc;

   logic [31:0]           sum_in;
   logic [15:0]           rs_in;

   logic                  rsp_valid_ff;
   logic [15:0]           rsp_refl_ff;
   logic                  rsp_tir_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // clamp, then fold a negative cosine by swapping the indices
   always_comb begin
      cos_s = req_cos_incident;
      if (cos_s > $signed(fdr_pkg::ONE_Q14)) begin
         cos_c = $signed(fdr_pkg::ONE_Q14);
      end else if (cos_s < -$signed(fdr_pkg::ONE_Q14)) begin
         cos_c = -$signed(fdr_pkg::ONE_Q14);
      end else begin
         cos_c = cos_s;
      end
      in_side_in.tir = 1'b0;
      if (cos_c < 0) begin
         in_side_in.cu = 15'(-cos_c);
         in_side_in.ni = req_ior_inside;
         in_side_in.nt = req_ior_outside;
      end else begin
         in_side_in.cu = 15'(cos_c);
         in_side_in.ni = req_ior_outside;
         in_side_in.nt = req_ior_inside;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_side_ff <= in_side_in;
      end
   end

   fdr_sqrt u_sqrt_i (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_v_ff),
      .in_x      (in_side_ff.cu),
      .in_side   (in_side_ff),
      .out_valid (s1_valid),
      .out_root  (s1_root),
      .out_side  (s1_side)
   );

   always_comb begin
      t_side_in     = p_side_ff;
      t_side_in.tir = p_ff >= {1'b0, p_side_ff.nt, 14'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         t_v_ff <= 1'b0;
      end else if (en) begin
         p_v_ff <= s1_valid;
         t_v_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff      <= 31'(s1_side.ni) * 31'(s1_root);
         p_side_ff <= s1_side;
         t_prod_ff <= p_ff;
         t_side_ff <= t_side_in;
      end
   end

   fdr_snell u_snell (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t_v_ff),
      .in_prod   (t_prod_ff),
      .in_side   (t_side_ff),
      .out_valid (sn_valid),
      .out_quo   (sn_quo),
      .out_side  (sn_side)
   );

   fdr_sqrt u_sqrt_t (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sn_valid),
      .in_x      ({1'b0, sn_quo}),
      .in_side   (sn_side),
      .out_valid (s2_valid),
      .out_root  (s2_root),
      .out_side  (s2_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else if (en) begin
         m_v_ff <= s2_valid;
         d_v_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_tir_ff <= s2_side.tir;
         ma_ff[0] <= 31'(s2_side.nt) * 31'(s2_side.cu);
         mb_ff[0] <= 31'(s2_side.ni) * 31'(s2_root);
         ma_ff[1] <= 31'(s2_side.ni) * 31'(s2_side.cu);
         mb_ff[1] <= 31'(s2_side.nt) * 31'(s2_root);
         d_tir_ff <= m_tir_ff;
         for (int l = 0; l < 2; l++) begin
            num_ff[l] <= (ma_ff[l] >= mb_ff[l]) ? {1'b0, ma_ff[l] - mb_ff[l]}
                                                : {1'b0, mb_ff[l] - ma_ff[l]};
            den_ff[l] <= {1'b0, ma_ff[l]} + {1'b0, mb_ff[l]};
         end
      end
   end

   fdr_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_v_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_tir    (d_tir_ff),
      .out_valid (r_valid),
      .out_quo   (r_quo),
      .out_tir   (r_tir)
   );

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         qc[l] = (r_quo[l] > fdr_pkg::ONE_Q15) ? fdr_pkg::ONE_Q15 : r_quo[l];
      end
   end

   always_comb begin
      sum_in = {1'b0, qsq_ff[0]} + {1'b0, qsq_ff[1]} + 32'd32768;
      rs_in  = (sum_in[31:16] > fdr_pkg::ONE_Q15) ? fdr_pkg::ONE_Q15 : sum_in[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         q_v_ff       <= r_valid;
         rsp_valid_ff <= q_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_tir_ff  <= r_tir;
         qsq_ff[0] <= 31'(qc[0]) * 31'(qc[0]);
         qsq_ff[1] <= 31'(qc[1]) * 31'(qc[1]);
         rsp_tir_ff  <= q_tir_ff;
         rsp_refl_ff <= q_tir_ff ? fdr_pkg::ONE_Q15 : rs_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reflectance    = rsp_refl_ff;
   assign rsp_total_internal = rsp_tir_ff;

endmodule

`default_nettype wire

// ===== rtl/core/fdr_checker.sv =====
// ----------------------------------------------------------------------------
// Fresnel reflectance checker
// Port-level properties of the reflectance unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fdr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [15:0] req_cos_incident,
   input wire logic [15:0] req_ior_outside,
   input wire logic [15:0] req_ior_inside,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_reflectance,
   input wire logic        rsp_total_internal
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reflectance)
                                  && $stable(rsp_total_internal))
      else $error("stalled result beat changed");

   a_tir_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_total_internal |-> rsp_reflectance == 16'd32768)
      else $error("total internal reflection without full reflectance");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reflectance <= 16'd32768)
      else $error("reflectance above one");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output stall");

endmodule

bind dielectric_fresnel_reflectance_unit fdr_checker u_fdr_checker (.*);

`default_nettype wire
